>>> hw/rtl/mfp_pkg.sv
package mfp_pkg;

  localparam int unsigned NumCodes  = 24;
  localparam int unsigned PayBytes  = 14;
  localparam int unsigned HdrBytes  = 8;
  localparam int unsigned LenBytes  = 4;
  localparam int unsigned IdxMax    = 22;
  localparam int unsigned NumFields = 7;

  localparam logic [1:0] StatusOk       = 2'd0;
  localparam logic [1:0] StatusShort    = 2'd1;
  localparam logic [1:0] StatusTooShort = 2'd2;

  localparam logic [4:0] TypeDinf    = 5'd1;
  localparam logic [4:0] TypeCinn    = 5'd5;
  localparam logic [4:0] TypeDmmv    = 5'd7;
  localparam logic [4:0] TypeDmrm    = 5'd8;
  localparam logic [4:0] TypeDmup    = 5'd9;
  localparam logic [4:0] TypeDmdn    = 5'd10;
  localparam logic [4:0] TypeDmwm    = 5'd11;
  localparam logic [4:0] TypeDkup    = 5'd12;
  localparam logic [4:0] TypeDkdn    = 5'd13;
  localparam logic [4:0] TypeDkrp    = 5'd14;
  localparam logic [4:0] TypeDclp    = 5'd16;
  localparam logic [4:0] TypeEicv    = 5'd21;
  localparam logic [4:0] TypeUnknown = 5'd24;

  typedef logic [31:0] code_arr_t [NumCodes];
  typedef logic [3:0]  min_arr_t  [NumCodes + 1];

  localparam code_arr_t CodeTable = '{
    "QINF", "DINF", "CIAK", "CALV", "CNOP", "CINN", "COUT", "DMMV",
    "DMRM", "DMUP", "DMDN", "DMWM", "DKUP", "DKDN", "DKRP", "CCLP",
    "DCLP", "CBYE", "EUNK", "EBSY", "EBAD", "EICV", "CROP", "DSOP"
  };

  // minimum payload data length per type, last entry for unknown
  localparam min_arr_t MinLen = '{
    4'd0, 4'd14, 4'd0, 4'd0, 4'd0, 4'd10, 4'd0, 4'd4, 4'd4, 4'd1, 4'd1, 4'd4, 4'd6,
    4'd6, 4'd8, 4'd5, 4'd5, 4'd0, 4'd0, 4'd0, 4'd0, 4'd4, 4'd0, 4'd0, 4'd0
  };

  typedef struct packed {
    logic [4:0]                count;
    logic [31:0]               length;
    logic [31:0]               code;
    logic [PayBytes-1:0][7:0]  payload;
  } frame_t;

  typedef struct packed {
    logic [1:0]                 status;
    logic [4:0]                 message_type;
    logic [NumFields-1:0][31:0] field;
  } result_t;

endpackage

>>> hw/rtl/mfp_in_if.sv
interface mfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic       last_byte;

  modport source (output valid, output byte_in, output last_byte, input ready);
  modport sink   (input valid, input byte_in, input last_byte, output ready);
endinterface

>>> hw/rtl/mfp_out_if.sv
interface mfp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [4:0]  message_type;
  logic [31:0] field_0;
  logic [31:0] field_1;
  logic [31:0] field_2;
  logic [31:0] field_3;
  logic [31:0] field_4;
  logic [31:0] field_5;
  logic [31:0] field_6;

  modport source (output valid, output status, output message_type, output field_0,
                  output field_1, output field_2, output field_3, output field_4,
                  output field_5, output field_6, input ready);
  modport sink   (input valid, input status, input message_type, input field_0,
                  input field_1, input field_2, input field_3, input field_4,
                  input field_5, input field_6, output ready);
endinterface

>>> hw/rtl/mfp_frame_acc.sv
module mfp_frame_acc
  import mfp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       beat_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  input  logic       advance_i,
  output logic       frame_valid_o,
  output frame_t     frame_o
);

  frame_t acc_q, acc_d;
  frame_t frame_q;
  logic   frame_valid_q;

  always_comb begin
    acc_d = acc_q;
    if (acc_q.count < 5'(IdxMax)) begin
      if (acc_q.count < 5'(LenBytes)) begin
        acc_d.length = {acc_q.length[23:0], byte_i};
      end else if (acc_q.count < 5'(HdrBytes)) begin
        acc_d.code = {acc_q.code[23:0], byte_i};
      end else begin
        for (int k = 0; k < PayBytes; k++) begin
          if (acc_q.count == 5'(HdrBytes + k)) acc_d.payload[k] = byte_i;
        end
      end
      acc_d.count = acc_q.count + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q         <= '0;
      frame_valid_q <= 1'b0;
    end else begin
      frame_valid_q <= (beat_i && last_i) || (frame_valid_q && !advance_i);
      if (beat_i) begin
        // a finished frame starts the next one from scratch
        acc_q <= last_i ? '0 : acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (beat_i && last_i) frame_q <= acc_d;
  end

  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

endmodule

>>> hw/rtl/mfp_decode.sv
module mfp_decode
  import mfp_pkg::*;
(
  input  frame_t  frame_i,
  output result_t result_o
);

  function automatic logic [15:0] rd16(input logic [PayBytes-1:0][7:0] p,
                                       input logic [3:0] pos);
    return {p[pos], p[pos + 4'd1]};
  endfunction

  function automatic logic [31:0] ux16(input logic [15:0] v);
    return {16'd0, v};
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  logic [4:0]  msg_type;
  logic [31:0] pay_len;
  logic [PayBytes-1:0][7:0] p;

  assign p = frame_i.payload;

  always_comb begin
    msg_type = TypeUnknown;
    for (int i = NumCodes - 1; i >= 0; i--) begin
      if (frame_i.code == CodeTable[i]) msg_type = 5'(i);
    end
  end

  assign pay_len = (frame_i.length >= 32'(LenBytes)) ? frame_i.length - 32'(LenBytes) : '0;

  always_comb begin
    result_o              = '0;
    result_o.message_type = msg_type;
    if (frame_i.count < 5'(HdrBytes)) begin
      result_o.status       = StatusShort;
      result_o.message_type = TypeUnknown;
    end else if (pay_len < {28'd0, MinLen[msg_type]}) begin
      result_o.status = StatusTooShort;
    end else begin
      case (msg_type) inside
        TypeDinf: begin
          for (int i = 0; i < NumFields; i++) begin
            result_o.field[i] = ux16(rd16(p, 4'(2 * i)));
          end
        end
        TypeDmmv, TypeEicv: begin
          result_o.field[0] = ux16(rd16(p, 4'd0));
          result_o.field[1] = ux16(rd16(p, 4'd2));
        end
        TypeDmrm, TypeDmwm: begin
          result_o.field[0] = sx16(rd16(p, 4'd0));
          result_o.field[1] = sx16(rd16(p, 4'd2));
        end
        TypeDmup, TypeDmdn: begin
          result_o.field[0] = {{24{p[0][7]}}, p[0]};
        end
        TypeCinn: begin
          result_o.field[0] = ux16(rd16(p, 4'd0));
          result_o.field[1] = ux16(rd16(p, 4'd2));
          result_o.field[2] = {rd16(p, 4'd4), rd16(p, 4'd6)};
          result_o.field[3] = ux16(rd16(p, 4'd8));
        end
        TypeDkup, TypeDkdn: begin
          result_o.field[0] = ux16(rd16(p, 4'd0));
          result_o.field[1] = ux16(rd16(p, 4'd2));
          result_o.field[2] = ux16(rd16(p, 4'd4));
        end
        TypeDkrp: begin
          result_o.field[0] = ux16(rd16(p, 4'd0));
          result_o.field[1] = ux16(rd16(p, 4'd2));
          result_o.field[2] = ux16(rd16(p, 4'd4));
          result_o.field[3] = ux16(rd16(p, 4'd6));
        end
        TypeDclp: begin
          result_o.field[0] = {24'd0, p[0]};
          result_o.field[1] = {p[1], p[2], p[3], p[4]};
        end
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/message_frame_parser_core.sv
// length-prefixed message parser, one byte per beat on in_i
// a message is a run of beats ending with last_byte high: four bytes of
// big-endian length, a four-character code, then up to 14 payload bytes;
// bytes past the 22nd are dropped, missing payload bytes read as zero
// each message gives exactly one result beat on out_o: status, message type
// and seven decoded 32-bit fields (signed ones sign-extended)
// throughput: one byte per cycle while in_i.ready is high, a new message may start on the cycle
// after a last byte
// the frame register loads on the edge that takes the last byte, and the result
// register loads from it once out_o can advance, so the result is presented
// from a register
// stall: while out_o is held off, the frame register holds the next finished
// message and in_i keeps taking bytes until a second last byte would need
// that register; ready then drops until the result is taken
// reset: the byte counter, header and payload are cleared, no result pending
module message_frame_parser_core
  import mfp_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  mfp_in_if.sink   in_i,
  mfp_out_if.source out_o
);

  logic    beat;
  logic    advance;
  logic    frame_valid;
  frame_t  frame;
  result_t result_d, result_q;
  logic    out_valid_q;

  assign advance    = !out_valid_q || out_o.ready;
  // non-last bytes only touch the accumulator, so they never wait
  assign in_i.ready = !in_i.last_byte || !frame_valid || advance;
  assign beat       = in_i.valid && in_i.ready;

  mfp_frame_acc u_acc (
    .clk_i,
    .rst_ni,
    .beat_i        (beat),
    .byte_i        (in_i.byte_in),
    .last_i        (in_i.last_byte),
    .advance_i     (advance),
    .frame_valid_o (frame_valid),
    .frame_o       (frame)
  );

  mfp_decode u_dec (
    .frame_i  (frame),
    .result_o (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= frame_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && frame_valid) result_q <= result_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = result_q.status;
  assign out_o.message_type = result_q.message_type;
  assign out_o.field_0      = result_q.field[0];
  assign out_o.field_1      = result_q.field[1];
  assign out_o.field_2      = result_q.field[2];
  assign out_o.field_3      = result_q.field[3];
  assign out_o.field_4      = result_q.field[4];
  assign out_o.field_5      = result_q.field[5];
  assign out_o.field_6      = result_q.field[6];

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb
  import mfp_pkg::*;
();

  localparam int unsigned RandomBytes = 370;
  localparam int unsigned IdleLimit   = 3000;
  localparam int unsigned HoldCycles  = 300;

  localparam logic [31:0] KnownCodes [24] = '{
    "QINF", "DINF", "CIAK", "CALV", "CNOP", "CINN", "COUT", "DMMV",
    "DMRM", "DMUP", "DMDN", "DMWM", "DKUP", "DKDN", "DKRP", "CCLP",
    "DCLP", "CBYE", "EUNK", "EBSY", "EBAD", "EICV", "CROP", "DSOP"
  };

  // smallest declared payload per type, last entry for unknown codes
  localparam int unsigned MinPayload [25] = '{
    0, 14, 0, 0, 0, 10, 0, 4, 4, 1, 1, 4, 6, 6, 8, 5, 5, 0, 0, 0, 0, 4, 0, 0, 0
  };

  // payload fill patterns
  localparam int unsigned FillRandom = 0;
  localparam int unsigned FillOnes   = 1;
  localparam int unsigned FillZeros  = 2;
  localparam int unsigned FillSign   = 3;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         drain_first;
  } beat_t;

  logic clk;
  logic rst_n;

  mfp_in_if  in_if ();
  mfp_out_if out_if ();

  message_frame_parser_core u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_if),
    .out_o (out_if)
  );

  beat_t       pending_q [$];
  result_t     expected_q [$];
  beat_t       nxt;
  int unsigned gap_left;
  int unsigned stall_left;
  bit          hold_off;
  bit          calm;
  int unsigned bytes_taken;
  int unsigned results_seen;
  int unsigned idle_cycles;
  int unsigned mismatches = 0;

  // predictor state for the message being assembled
  int unsigned msg_count;
  logic [31:0] msg_len;
  logic [31:0] msg_code;
  logic [7:0]  msg_payload [14];

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [31:0] be16(input int unsigned pos);
    return {16'h0, msg_payload[pos], msg_payload[pos + 1]};
  endfunction

  function automatic logic [31:0] be32(input int unsigned pos);
    return (be16(pos) << 16) | be16(pos + 2);
  endfunction

  function automatic logic [31:0] sext16(input logic [31:0] v);
    return {{16{v[15]}}, v[15:0]};
  endfunction

  function automatic void clear_message();
    msg_count = 0;
    msg_len   = '0;
    msg_code  = '0;
    foreach (msg_payload[k]) msg_payload[k] = '0;
  endfunction

  // folds one byte into the message, returns 1 with the decoded frame on the last byte
  function automatic bit absorb_byte(input logic [7:0] b, input logic last,
                                     output result_t r);
    int unsigned k;
    logic [31:0] pay_len;
    logic [4:0]  kind;
    r = '0;
    if (msg_count < 4) msg_len = {msg_len[23:0], b};
    else if (msg_count < 8) msg_code = {msg_code[23:0], b};
    else if (msg_count < 22) msg_payload[msg_count - 8] = b;
    if (msg_count < 22) msg_count++;
    if (!last) return 0;
    kind = TypeUnknown;
    if (msg_count < 8) begin
      r.status = StatusShort;
    end else begin
      for (k = 0; k < 24; k++) begin
        if (KnownCodes[k] == msg_code && kind == TypeUnknown) kind = k[4:0];
      end
      pay_len = (msg_len >= 4) ? msg_len - 4 : 32'd0;
      if (pay_len < MinPayload[kind]) begin
        r.status = StatusTooShort;
      end else begin
        r.status = StatusOk;
        case (kind)
          TypeDinf: begin
            for (k = 0; k < 7; k++) r.field[k] = be16(2 * k);
          end
          TypeDmmv, TypeEicv: begin
            r.field[0] = be16(0);
            r.field[1] = be16(2);
          end
          TypeDmrm, TypeDmwm: begin
            r.field[0] = sext16(be16(0));
            r.field[1] = sext16(be16(2));
          end
          TypeDmup, TypeDmdn: begin
            r.field[0] = {{24{msg_payload[0][7]}}, msg_payload[0]};
          end
          TypeCinn: begin
            r.field[0] = be16(0);
            r.field[1] = be16(2);
            r.field[2] = be32(4);
            r.field[3] = be16(8);
          end
          TypeDkup, TypeDkdn: begin
            r.field[0] = be16(0);
            r.field[1] = be16(2);
            r.field[2] = be16(4);
          end
          TypeDkrp: begin
            r.field[0] = be16(0);
            r.field[1] = be16(2);
            r.field[2] = be16(4);
            r.field[3] = be16(6);
          end
          TypeDclp: begin
            r.field[0] = {24'h0, msg_payload[0]};
            r.field[1] = be32(1);
          end
          default: ;
        endcase
      end
    end
    r.message_type = kind;
    clear_message();
    return 1;
  endfunction

  task automatic add_message(input logic [31:0] code, input logic [31:0] len,
                             input int unsigned n, input int unsigned fill,
                             input bit drain);
    beat_t       bt;
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (i < 4) bt.data = len[31 - 8 * i -: 8];
      else if (i < 8) bt.data = code[31 - 8 * (i - 4) -: 8];
      else if (fill == FillOnes) bt.data = 8'hFF;
      else if (fill == FillZeros) bt.data = 8'h00;
      else if (fill == FillSign) bt.data = (i % 2 == 0) ? 8'h80 : 8'h00;
      else bt.data = 8'($urandom_range(255));
      bt.last        = (i == n - 1);
      bt.drain_first = drain && (i == 0);
      pending_q.push_back(bt);
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // sender
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.byte_in   <= '0;
      in_if.last_byte <= 1'b0;
      gap_left        <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (gap_left != 0) begin
        gap_left    <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (pending_q.size() == 0) begin
        in_if.valid <= 1'b0;
      end else if (pending_q[0].drain_first && (expected_q.size() != 0 ||
                   (in_if.valid && in_if.ready && in_if.last_byte))) begin
        // hold until every outstanding frame has come back
        in_if.valid <= 1'b0;
      end else begin
        nxt = pending_q.pop_front();
        in_if.valid     <= 1'b1;
        in_if.byte_in   <= nxt.data;
        in_if.last_byte <= nxt.last;
        gap_left        <= pick_gap();
      end
    end
  end

  // receiver
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_left   <= 0;
    end else if (hold_off) begin
      out_if.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      stall_left   <= pick_gap();
    end
  end

  // long receiver hold-off so the parser backs up into its input
  initial begin
    hold_off = 1'b0;
    while (results_seen < 6) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    hold_off <= 1'b0;
  end

  // stretches without any gaps or stalls
  initial begin
    calm = 1'b0;
    forever begin
      repeat ($urandom_range(100, 400)) @(posedge clk);
      calm <= ~calm;
    end
  end

  // checker and predictor
  always @(posedge clk or negedge rst_n) begin
    result_t     got_exp;
    result_t     new_exp;
    logic [31:0] got [7];
    if (!rst_n) begin
      clear_message();
      bytes_taken  <= 0;
      results_seen <= 0;
      idle_cycles  <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen <= results_seen + 1;
        if (expected_q.size() == 0) begin
          $error("result beat with no frame outstanding");
          mismatches++;
        end else begin
          got_exp = expected_q.pop_front();
          got = '{out_if.field_0, out_if.field_1, out_if.field_2, out_if.field_3,
                  out_if.field_4, out_if.field_5, out_if.field_6};
          if (out_if.status !== got_exp.status) begin
            $error("status mismatch: expected %0d, actual %0d", got_exp.status,
                   out_if.status);
            mismatches++;
          end
          if (out_if.message_type !== got_exp.message_type) begin
            $error("message_type mismatch: expected %0d, actual %0d",
                   got_exp.message_type, out_if.message_type);
            mismatches++;
          end
          for (int k = 0; k < 7; k++) begin
            if (got[k] !== got_exp.field[k]) begin
              $error("field_%0d mismatch: expected %08h, actual %08h", k,
                     got_exp.field[k], got[k]);
              mismatches++;
            end
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        bytes_taken <= bytes_taken + 1;
        if (absorb_byte(in_if.byte_in, in_if.last_byte, new_exp))
          expected_q.push_back(new_exp);
      end
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= IdleLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned total;
    int unsigned r;
    int unsigned kind;
    int unsigned dlen;
    int unsigned npay;
    int unsigned fill;
    logic [31:0] len;
    logic [31:0] code;
    bit          drain;
    rst_n = 1'b0;

    // single byte and seven byte messages, both short
    add_message($urandom, $urandom, 1, FillRandom, 0);
    add_message($urandom, $urandom, 7, FillRandom, 0);
    // header only, no payload
    add_message("QINF", 32'd4, 8, FillRandom, 0);
    // full device info with every payload bit set
    add_message("DINF", 32'd18, 22, FillOnes, 0);
    // most negative relative move and largest declared length
    add_message("DMRM", 32'hFFFF_FFFF, 12, FillSign, 0);
    add_message("DMUP", 32'd5, 9, FillSign, 0);
    // declared payload one below the minimum
    add_message("CINN", 32'd13, 18, FillRandom, 0);
    // declared length below four counts as empty payload
    add_message("DCLP", 32'd3, 13, FillRandom, 0);
    add_message(32'h0, 32'h0, 8, FillZeros, 0);
    // bytes past the 22nd are dropped
    add_message("DKRP", 32'd12, 26, FillRandom, 0);
    // declared length fine but payload cut off, missing bytes read zero
    add_message("EICV", 32'd8, 9, FillRandom, 0);

    total = pending_q.size() + RandomBytes;
    drain = 1'b1;
    while (pending_q.size() < total) begin
      r    = $urandom_range(99);
      fill = ($urandom_range(99) < 70) ? FillRandom : $urandom_range(1, 3);
      if (r < 8) begin
        add_message($urandom, $urandom, $urandom_range(1, 7), FillRandom, drain);
      end else if (r < 16) begin
        add_message($urandom, $urandom_range(0, 20), $urandom_range(8, 24), fill, drain);
      end else begin
        kind = $urandom_range(23);
        if ($urandom_range(99) < 85 || MinPayload[kind] == 0)
          dlen = $urandom_range(MinPayload[kind], 14);
        else
          dlen = $urandom_range(0, MinPayload[kind] - 1);
        r = $urandom_range(99);
        if (r < 5) len = $urandom;
        else if (r < 8) len = $urandom_range(0, 3);
        else len = dlen + 4;
        r = $urandom_range(99);
        if (r < 70) npay = dlen;
        else if (r < 85) npay = $urandom_range(0, 14);
        else npay = $urandom_range(15, 20);
        add_message(KnownCodes[kind], len, 8 + npay, fill, drain);
      end
      drain = ($urandom_range(99) < 5);
    end
    total = pending_q.size();

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (bytes_taken != total || expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (expected_q.size() != 0)
      $error("%0d frames never came back", expected_q.size());
    if (mismatches == 0 && expected_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
